// ===== sv/tgt_pkg.sv =====
package tgt_pkg;

  localparam int ScreenWidth  = 320;
  localparam int ScreenHeight = 240;
  localparam int PressureMin  = 400;
  localparam int TapMinMs     = 50;
  localparam int SampleGapMs  = 12;
  localparam int MissLimit    = 3;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW = 72;
  localparam int OutDataW = 80;
  localparam int DivW = 29;
  localparam int DivCntW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SWAP_AXES  = 3'd0,
    REG_RAW_X_LOW  = 3'd1,
    REG_RAW_X_HIGH = 3'd2,
    REG_RAW_Y_LOW  = 3'd3,
    REG_RAW_Y_HIGH = 3'd4,
    REG_FLIP_180   = 3'd5,
    REG_LONG_MS    = 3'd6,
    REG_DRAG_THR   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start_x;
    logic div_start_y;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } stat_t;

endpackage

// ===== sv/tgt_ctrl.sv =====
module tgt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  input  tgt_pkg::stat_t stat_i,
  output tgt_pkg::cmd_t cmd_o
);
  import tgt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (stat_i.need_div) begin
          cmd_o.div_start_x = 1'b1;
          state_d = ST_DIV_Y;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_DIV_Y: begin
        if (!stat_i.div_busy) begin
          cmd_o.div_start_y = 1'b1;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!stat_i.div_busy) begin
          cmd_o.update = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DIV_X)
    else $error("load did not start item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> !stat_i.div_busy)
    else $error("update during divide");

endmodule

// ===== sv/tgt_div.sv =====
module tgt_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [tgt_pkg::DivW-1:0] num_i,
  input  logic [tgt_pkg::DivW-1:0] den_i,
  output logic                    busy_o,
  output logic [tgt_pkg::DivW-1:0] quo_o
);
  import tgt_pkg::*;

  logic [DivW-1:0] quo_q, quo_d, rem_q, rem_d, den_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [DivW:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = DivCntW'(DivW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o = quo_q;

endmodule

// ===== sv/tgt_dp.sv =====
module tgt_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [tgt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [tgt_pkg::InDataW-1:0]  in_data_i,
  input  tgt_pkg::cmd_t               cmd_i,
  output tgt_pkg::stat_t              stat_o,
  output logic [tgt_pkg::OutDataW-1:0] out_data_o
);
  import tgt_pkg::*;

  logic swap_q, flip_q;
  logic signed [15:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic [15:0] lpms_q;
  logic [9:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
      xlo_q <= 16'sd200;
      xhi_q <= 16'sd3900;
      ylo_q <= 16'sd240;
      yhi_q <= 16'sd3800;
      flip_q <= 1'b0;
      lpms_q <= 16'd600;
      thr_q <= 10'd12;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SWAP_AXES:  swap_q <= cfg_data_i[0];
        REG_RAW_X_LOW:  xlo_q <= cfg_data_i;
        REG_RAW_X_HIGH: xhi_q <= cfg_data_i;
        REG_RAW_Y_LOW:  ylo_q <= cfg_data_i;
        REG_RAW_Y_HIGH: yhi_q <= cfg_data_i;
        REG_FLIP_180:   flip_q <= cfg_data_i[0];
        REG_LONG_MS:    lpms_q <= cfg_data_i;
        REG_DRAG_THR:   thr_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // latched poll
  logic [31:0] now_q;
  logic [11:0] rx_q, ry_q, rz_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= in_data_i[31:0];
      rx_q <= in_data_i[43:32];
      ry_q <= in_data_i[55:44];
      rz_q <= in_data_i[67:56];
    end
  end

  // tracker state
  logic down_q, drag_q, ldone_q;
  logic signed [9:0] scol_q, lcol_q;
  logic signed [8:0] srow_q, lrow_q;
  logic [31:0] ptime_q, stime_q, atime_q;
  logic [1:0] miss_q;
  logic o_dn_q, o_dr_q, o_pr_q, o_rel_q, o_tap_q, o_lp_q;

  logic [31:0] dt_press, dt_samp;
  logic lp_pre, gap, touching;
  assign dt_press = now_q - ptime_q;
  assign dt_samp = now_q - stime_q;
  assign lp_pre = down_q && !ldone_q && !drag_q && (dt_press > {16'd0, lpms_q});
  assign gap = dt_samp < 32'(SampleGapMs);
  assign touching = rz_q >= 12'(PressureMin);
  assign stat_o.need_div = !lp_pre && !gap && touching;

  // divider operands: |raw - lo| * (span-1) over |hi - lo|
  logic signed [17:0] nx, ny, dx_den, dy_den;
  logic signed [12:0] ax, ay;
  assign ax = swap_q ? $signed({1'b0, ry_q}) : $signed({1'b0, rx_q});
  assign ay = swap_q ? $signed({1'b0, rx_q}) : $signed({1'b0, ry_q});
  assign nx = 18'(ax) - 18'(xlo_q);
  assign ny = 18'(ay) - 18'(ylo_q);
  assign dx_den = 18'(xhi_q) - 18'(xlo_q);
  assign dy_den = 18'(yhi_q) - 18'(ylo_q);

  logic neg_x, neg_y;
  assign neg_x = nx[17] ^ dx_den[17];
  assign neg_y = ny[17] ^ dy_den[17];

  logic [17:0] nxa, nya, dxa, dya;
  assign nxa = nx[17] ? 18'(-nx) : 18'(nx);
  assign nya = ny[17] ? 18'(-ny) : 18'(ny);
  assign dxa = dx_den[17] ? 18'(-dx_den) : 18'(dx_den);
  assign dya = dy_den[17] ? 18'(-dy_den) : 18'(dy_den);

  logic [DivW-1:0] num_x, num_y, div_num, div_den, quo;
  assign num_x = DivW'(nxa) * DivW'(ScreenWidth - 1);
  assign num_y = DivW'(nya) * DivW'(ScreenHeight - 1);
  assign div_num = cmd_i.div_start_x ? num_x : num_y;
  assign div_den = cmd_i.div_start_x ? DivW'(dxa) : DivW'(dya);

  tgt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start_x | cmd_i.div_start_y),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (stat_o.div_busy),
    .quo_o  (quo)
  );

  logic [DivW-1:0] qx_q;
  logic div_y_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_y_pend_q <= 1'b0;
    end else if (cmd_i.div_start_y) begin
      div_y_pend_q <= 1'b1;
    end else if (cmd_i.load) begin
      div_y_pend_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start_y) begin
      qx_q <= quo;
    end
  end

  // clamp: negative quotient or zero span -> 0, above span-1 -> span-1; then optional flip
  logic signed [10:0] sx, sy;
  always_comb begin
    if (dxa == '0 || neg_x) begin
      sx = '0;
    end else if (qx_q > DivW'(ScreenWidth - 1)) begin
      sx = 11'(ScreenWidth - 1);
    end else begin
      sx = 11'(qx_q);
    end
    if (dya == '0 || neg_y) begin
      sy = '0;
    end else if (quo > DivW'(ScreenHeight - 1)) begin
      sy = 11'(ScreenHeight - 1);
    end else begin
      sy = 11'(quo);
    end
    if (flip_q) begin
      sx = 11'(ScreenWidth - 1) - sx;
      sy = 11'(ScreenHeight - 1) - sy;
    end
  end

  logic signed [11:0] ddx, ddy;
  logic [11:0] adx, ady;
  assign ddx = 12'(sx) - 12'(scol_q);
  assign ddy = 12'(sy) - 12'(srow_q);
  assign adx = ddx[11] ? 12'(-ddx) : 12'(ddx);
  assign ady = ddy[11] ? 12'(-ddy) : 12'(ddy);

  logic drag_new;
  assign drag_new = drag_q || adx > {2'b0, thr_q} || ady > {2'b0, thr_q};

  logic [1:0] miss_inc;
  assign miss_inc = miss_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= 1'b0;
      drag_q <= 1'b0;
      ldone_q <= 1'b0;
      scol_q <= '1;
      srow_q <= '1;
      lcol_q <= '1;
      lrow_q <= '1;
      ptime_q <= '0;
      stime_q <= '0;
      atime_q <= '0;
      miss_q <= '0;
      {o_dn_q, o_dr_q, o_pr_q, o_rel_q, o_tap_q, o_lp_q} <= '0;
    end else if (cmd_i.update) begin
      {o_dn_q, o_dr_q, o_pr_q, o_rel_q, o_tap_q, o_lp_q} <=
        {down_q, drag_q, 4'b0};
      if (lp_pre) begin
        ldone_q <= 1'b1;
        {o_dn_q, o_dr_q, o_lp_q} <= 3'b101;
      end else if (!gap) begin
        stime_q <= now_q;
        if (touching) begin
          miss_q <= '0;
          lcol_q <= 10'(sx);
          lrow_q <= 9'(sy);
          atime_q <= now_q;
          if (!down_q) begin
            down_q <= 1'b1;
            drag_q <= 1'b0;
            ldone_q <= 1'b0;
            ptime_q <= now_q;
            scol_q <= 10'(sx);
            srow_q <= 9'(sy);
            {o_dn_q, o_dr_q, o_pr_q} <= 3'b101;
          end else begin
            drag_q <= drag_new;
            o_dn_q <= 1'b1;
            o_dr_q <= drag_new;
            if (!ldone_q && !drag_new && dt_press > {16'd0, lpms_q}) begin
              ldone_q <= 1'b1;
              o_lp_q <= 1'b1;
            end
          end
        end else if (down_q) begin
          if (miss_inc < 2'(MissLimit)) begin
            miss_q <= miss_inc;
          end else begin
            miss_q <= '0;
            down_q <= 1'b0;
            atime_q <= now_q;
            o_dn_q <= 1'b0;
            o_rel_q <= 1'b1;
            o_tap_q <= !drag_q && !ldone_q && dt_press >= 32'(TapMinMs);
          end
        end
      end
    end
  end

  assign out_data_o = {
    4'd0, atime_q, srow_q, scol_q, lrow_q, lcol_q,
    o_lp_q, o_tap_q, o_rel_q, o_pr_q, o_dr_q, o_dn_q
  };

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && div_y_pend_q |-> !stat_o.div_busy)
    else $error("update before quotient ready");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> !(o_pr_q && o_rel_q))
    else $error("press and release together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> !(o_tap_q && !o_rel_q))
    else $error("tap without release");

endmodule

// ===== sv/touch_gesture_tracker_core.sv =====
// channel  dir  fields (low bit up)
// s_axis   in   tdata: now_ms[31:0] raw_x[43:32] raw_y[55:44] raw_z[67:56]
// m_axis   out  tdata: is_down is_dragging pressed released tap long_press
//                pos_x pos_y origin_x origin_y activity_ms
// cfg      in   index 0..7, data 16 bits
// A poll with a touching sample to map runs two 29-step passes of the shared
// restoring divider, X then Y, before its result is formed; any other poll
// skips the divider.
// Reset brings the config registers to their defaults and the tracker to idle.
// A result waits in its register until taken; no poll is accepted meanwhile,
// so a low m_tready_i holds off the next poll.
module touch_gesture_tracker_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [tgt_pkg::InDataW-1:0]  s_tdata_i,  // now_ms raw_x raw_y raw_z
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [tgt_pkg::OutDataW-1:0] m_tdata_o,  // is_down is_dragging pressed
                                                   // released tap long_press
                                                   // pos_x pos_y origin_x
                                                   // origin_y activity_ms
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tgt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgt_pkg::CfgDataW-1:0] cfg_data_i
);
  import tgt_pkg::*;

  cmd_t cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tgt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tgt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_tdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_tdata_o)
  );

endmodule
